/* rtl/lsss_pkg.sv */
// Shared types and constants for the limit-stopped stepper sweep unit.
// No dependencies; used by every module of the block.
package lsss_pkg;

  localparam int unsigned CNT_W     = 16;
  localparam int unsigned CFG_IDX_W = 3;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_HIGH_TICKS     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LOW_TICKS      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SETTLE_TICKS   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_STEPS_PER_MOVE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PAUSE_TICKS    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_RETRY_TICKS    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_STARTUP_TICKS  = 3'd6;

  // Reset values of the configuration registers
  localparam logic [CNT_W-1:0] RST_HIGH_TICKS     = 16'd5;
  localparam logic [CNT_W-1:0] RST_LOW_TICKS      = 16'd4;
  localparam logic [CNT_W-1:0] RST_SETTLE_TICKS   = 16'd20;
  localparam logic [CNT_W-1:0] RST_STEPS_PER_MOVE = 16'd400;
  localparam logic [CNT_W-1:0] RST_PAUSE_TICKS    = 16'd1000;
  localparam logic [CNT_W-1:0] RST_RETRY_TICKS    = 16'd100;
  localparam logic [CNT_W-1:0] RST_STARTUP_TICKS  = 16'd500;

  // Sequencer phases
  typedef enum logic [2:0] {
    PH_STARTUP   = 3'd0,
    PH_CHECK_CW  = 3'd1,
    PH_CHECK_ACW = 3'd2,
    PH_SETTLE    = 3'd3,
    PH_HIGH      = 3'd4,
    PH_LOW       = 3'd5,
    PH_PAUSE     = 3'd6,
    PH_RETRY     = 3'd7
  } phase_t;

  // Live configuration, register file to sequencer
  typedef struct packed {
    logic [CNT_W-1:0] high_ticks;
    logic [CNT_W-1:0] low_ticks;
    logic [CNT_W-1:0] settle_ticks;
    logic [CNT_W-1:0] steps_per_move;
    logic [CNT_W-1:0] pause_ticks;
    logic [CNT_W-1:0] retry_ticks;
    logic [CNT_W-1:0] startup_ticks;
  } cfg_t;

  // One result beat
  typedef struct packed {
    logic step_out;
    logic dir_out;
    logic moving;
    logic limit_abort;
  } result_t;

endpackage

/* rtl/lsss_cfg_regs.sv */
// Configuration register file of the stepper sweep unit.
// Depends on lsss_pkg for register indexes, reset values and cfg_t.
module lsss_cfg_regs (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_wr_en,
  input  logic [lsss_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [lsss_pkg::CNT_W-1:0]         cfg_wdata,
  output lsss_pkg::cfg_t                     cfg
);

  lsss_pkg::cfg_t cfg_r;

  // Write-only registers; writes beyond the last index fall through
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.high_ticks     <= lsss_pkg::RST_HIGH_TICKS;
      cfg_r.low_ticks      <= lsss_pkg::RST_LOW_TICKS;
      cfg_r.settle_ticks   <= lsss_pkg::RST_SETTLE_TICKS;
      cfg_r.steps_per_move <= lsss_pkg::RST_STEPS_PER_MOVE;
      cfg_r.pause_ticks    <= lsss_pkg::RST_PAUSE_TICKS;
      cfg_r.retry_ticks    <= lsss_pkg::RST_RETRY_TICKS;
      cfg_r.startup_ticks  <= lsss_pkg::RST_STARTUP_TICKS;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        lsss_pkg::REG_HIGH_TICKS:     cfg_r.high_ticks     <= cfg_wdata;
        lsss_pkg::REG_LOW_TICKS:      cfg_r.low_ticks      <= cfg_wdata;
        lsss_pkg::REG_SETTLE_TICKS:   cfg_r.settle_ticks   <= cfg_wdata;
        lsss_pkg::REG_STEPS_PER_MOVE: cfg_r.steps_per_move <= cfg_wdata;
        lsss_pkg::REG_PAUSE_TICKS:    cfg_r.pause_ticks    <= cfg_wdata;
        lsss_pkg::REG_RETRY_TICKS:    cfg_r.retry_ticks    <= cfg_wdata;
        lsss_pkg::REG_STARTUP_TICKS:  cfg_r.startup_ticks  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

/* rtl/lsss_seq.sv */
// Phase sequencer: state registers and per-tick next-state logic.
// Depends on lsss_pkg (phase_t, cfg_t, result_t).
module lsss_seq (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               fire,
  input  logic               pressed,
  input  lsss_pkg::cfg_t     cfg,
  output lsss_pkg::result_t  res
);

  localparam int unsigned W = lsss_pkg::CNT_W;

  lsss_pkg::phase_t phase_r, phase_nxt;
  logic [W-1:0]     tick_r, tick_nxt;
  logic [W-1:0]     steps_r, steps_nxt;
  logic             dir_r, dir_nxt;
  logic             step_r, step_nxt;

  logic [W-1:0]     tick_inc;
  logic [W-1:0]     steps_inc;
  logic [W-1:0]     wait_lim;
  logic             wait_done;
  logic             mov;
  logic             abrt;

  // Limit of the timed wait for the current phase
  always_comb begin
    case (phase_r)
      lsss_pkg::PH_STARTUP: wait_lim = cfg.startup_ticks;
      lsss_pkg::PH_SETTLE:  wait_lim = cfg.settle_ticks;
      lsss_pkg::PH_HIGH:    wait_lim = cfg.high_ticks;
      lsss_pkg::PH_LOW:     wait_lim = cfg.low_ticks;
      lsss_pkg::PH_PAUSE:   wait_lim = cfg.pause_ticks;
      default:              wait_lim = cfg.retry_ticks;
    endcase
  end

  // A wait ends when the bumped count reaches the limit or wraps
  assign tick_inc  = tick_r + 1'b1;
  assign steps_inc = steps_r + 1'b1;
  assign wait_done = (tick_inc >= wait_lim) || (tick_inc == '0);

  // Next state and result of one tick
  always_comb begin
    phase_nxt = phase_r;
    tick_nxt  = wait_done ? '0 : tick_inc;
    steps_nxt = steps_r;
    dir_nxt   = dir_r;
    step_nxt  = step_r;
    mov       = 1'b0;
    abrt      = 1'b0;
    case (phase_r)
      lsss_pkg::PH_STARTUP: begin
        if (wait_done) phase_nxt = lsss_pkg::PH_CHECK_CW;
      end
      lsss_pkg::PH_CHECK_CW, lsss_pkg::PH_CHECK_ACW: begin
        tick_nxt = '0;
        if (pressed) begin
          step_nxt  = 1'b0;
          phase_nxt = lsss_pkg::PH_RETRY;
        end else begin
          dir_nxt   = (phase_r == lsss_pkg::PH_CHECK_ACW);
          steps_nxt = '0;
          phase_nxt = lsss_pkg::PH_SETTLE;
        end
      end
      lsss_pkg::PH_SETTLE: begin
        mov      = 1'b1;
        step_nxt = 1'b0;
        if (wait_done)
          phase_nxt = (steps_r >= cfg.steps_per_move) ? lsss_pkg::PH_PAUSE
                                                      : lsss_pkg::PH_HIGH;
      end
      lsss_pkg::PH_HIGH, lsss_pkg::PH_LOW: begin
        mov = 1'b1;
        if (tick_r == '0 && pressed) begin
          // switch hit at a pulse boundary: cut the move short
          tick_nxt  = tick_r;
          step_nxt  = 1'b0;
          abrt      = 1'b1;
          phase_nxt = lsss_pkg::PH_PAUSE;
        end else if (phase_r == lsss_pkg::PH_HIGH) begin
          step_nxt = 1'b1;
          if (wait_done) phase_nxt = lsss_pkg::PH_LOW;
        end else begin
          step_nxt = 1'b0;
          if (wait_done) begin
            steps_nxt = steps_inc;
            phase_nxt = (steps_inc >= cfg.steps_per_move) ? lsss_pkg::PH_PAUSE
                                                          : lsss_pkg::PH_HIGH;
          end
        end
      end
      lsss_pkg::PH_PAUSE: begin
        step_nxt = 1'b0;
        if (wait_done)
          phase_nxt = dir_r ? lsss_pkg::PH_CHECK_CW : lsss_pkg::PH_CHECK_ACW;
      end
      default: begin
        // retry wait after a refused start
        step_nxt = 1'b0;
        if (wait_done) phase_nxt = lsss_pkg::PH_CHECK_CW;
      end
    endcase
  end

  // State registers, advanced once per tick beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= lsss_pkg::PH_STARTUP;
      tick_r  <= '0;
      steps_r <= '0;
      dir_r   <= 1'b0;
      step_r  <= 1'b0;
    end else if (fire) begin
      phase_r <= phase_nxt;
      tick_r  <= tick_nxt;
      steps_r <= steps_nxt;
      dir_r   <= dir_nxt;
      step_r  <= step_nxt;
    end
  end

  assign res.step_out    = step_nxt;
  assign res.dir_out     = dir_nxt;
  assign res.moving      = mov;
  assign res.limit_abort = abrt;

endmodule

/* rtl/limit_stopped_stepper_sweep_unit.sv */
// Stepper sweep unit: one result beat per tick beat, passing from input
// accept to result valid through the input register, then the result register.
// Throughput one beat per cycle while out_stall is low; the sequencer
// advances when the input register hands its beat to the result register.
// Reset (rst_n low, synchronous) empties both registers, loads register
// defaults and returns the sequencer to the startup wait.
module limit_stopped_stepper_sweep_unit (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_wr_en,
  input  logic [lsss_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [lsss_pkg::CNT_W-1:0]         cfg_wdata,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic                               in_limit_pressed,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic                               out_step_out,
  output logic                               out_dir_out,
  output logic                               out_moving,
  output logic                               out_limit_abort
);

  lsss_pkg::cfg_t    cfg;
  lsss_pkg::result_t res;
  lsss_pkg::result_t res_r;

  logic s1_valid_r;
  logic s1_pressed_r;
  logic out_valid_r;
  logic adv;
  logic fire;

  // Result register frees up when empty or taken this cycle
  assign adv      = !out_valid_r || !out_stall;
  assign in_stall = s1_valid_r && !adv;
  assign fire     = s1_valid_r && adv;

  lsss_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  lsss_seq u_seq (
    .clk     (clk),
    .rst_n   (rst_n),
    .fire    (fire),
    .pressed (s1_pressed_r),
    .cfg     (cfg),
    .res     (res)
  );

  // Valid flags of the input and result registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (!in_stall) s1_valid_r <= in_valid;
      if (adv) out_valid_r <= s1_valid_r;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) s1_pressed_r <= in_limit_pressed;
    if (fire) res_r <= res;
  end

  assign out_valid       = out_valid_r;
  assign out_step_out    = res_r.step_out;
  assign out_dir_out     = res_r.dir_out;
  assign out_moving      = res_r.moving;
  assign out_limit_abort = res_r.limit_abort;

endmodule

/* rtl/lsss_checker.sv */
// Port-level checks for the stepper sweep unit, bound to the top level.
// Depends on lsss_pkg for port widths.
module lsss_checker (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               cfg_wr_en,
  input logic [lsss_pkg::CFG_IDX_W-1:0]     cfg_index,
  input logic [lsss_pkg::CNT_W-1:0]         cfg_wdata,
  input logic                               in_valid,
  input logic                               in_stall,
  input logic                               in_limit_pressed,
  input logic                               out_valid,
  input logic                               out_stall,
  input logic                               out_step_out,
  input logic                               out_dir_out,
  input logic                               out_moving,
  input logic                               out_limit_abort
);

  // Stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_step_out) &&
    $stable(out_dir_out) && $stable(out_moving) && $stable(out_limit_abort))
    else $error("stalled result beat changed");

  // An abort beat drops the step line inside a move
  a_abort_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_limit_abort |-> !out_step_out && out_moving)
    else $error("abort beat with step high or outside a move");

  // Step line is only high while pulsing
  a_step_in_move: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_step_out |-> out_moving)
    else $error("step high outside a move");

  // Reset empties the result register
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind limit_stopped_stepper_sweep_unit lsss_checker u_lsss_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .cfg_wr_en        (cfg_wr_en),
  .cfg_index        (cfg_index),
  .cfg_wdata        (cfg_wdata),
  .in_valid         (in_valid),
  .in_stall         (in_stall),
  .in_limit_pressed (in_limit_pressed),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_step_out     (out_step_out),
  .out_dir_out      (out_dir_out),
  .out_moving       (out_moving),
  .out_limit_abort  (out_limit_abort)
);
